### hdl/mm_pkg.sv
// Shared types and constants for the integer matrix multiply block.
// Depends on nothing; every other file of the block but mm_if imports it.
package mm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_W       = 4;
    localparam int REG_IDX_W   = 2;

    localparam logic [REG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLS_A = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROWS_B = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B = 2'd3;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_COMPUTE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] rows_a;
        logic [CFG_W-1:0] cols_a;
        logic [CFG_W-1:0] rows_b;
        logic [CFG_W-1:0] cols_b;
    } dims_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } back_state_t;

endpackage

### hdl/mm_if.sv
// Valid/ready stream interfaces for operand items and result items.
// Depends on nothing; comes after mm_pkg in the compile order.
interface mm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] entry_value;

    modport source (output valid, output opcode, output row_index, output col_index,
                    output entry_value, input ready);
    modport sink   (input valid, input opcode, input row_index, input col_index,
                    input entry_value, output ready);
endinterface

interface mm_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] product_value;
    logic               last;
    logic               dims_error;

    modport source (output valid, output out_row, output out_col, output product_value,
                    output last, output dims_error, input ready);
    modport sink   (input valid, input out_row, input out_col, input product_value,
                    input last, input dims_error, output ready);
endinterface

### hdl/mm_front.sv
// Front end: decode operand items into commands, drop the ones that do nothing.
// Depends on mm_pkg and mm_in_if.
module mm_front #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    mm_in_if.sink        operand,
    output logic         push,
    output mm_pkg::cmd_t push_cmd,
    input  logic         push_ready
);
    import mm_pkg::*;

    logic in_range;
    logic keep;

    // Out-of-range loads and the unused opcode are accepted and dropped.
    always_comb
    begin
        in_range = (32'(operand.row_index) < MAX_DIM) && (32'(operand.col_index) < MAX_DIM);
        push_cmd.row   = operand.row_index;
        push_cmd.col   = operand.col_index;
        push_cmd.value = operand.entry_value;
        case (operand.opcode)
            OP_LOAD_A:
            begin
                push_cmd.kind = CMD_LOAD_A;
                keep          = in_range;
            end
            OP_LOAD_B:
            begin
                push_cmd.kind = CMD_LOAD_B;
                keep          = in_range;
            end
            OP_COMPUTE:
            begin
                push_cmd.kind = CMD_COMPUTE;
                keep          = 1'b1;
            end
            default:
            begin
                push_cmd.kind = CMD_COMPUTE;
                keep          = 1'b0;
            end
        endcase
    end

    assign operand.ready = push_ready;
    assign push          = operand.valid && push_ready && keep;

endmodule

### hdl/mm_queue.sv
// Short command queue between the front end and the back end.
// Depends on mm_pkg.
module mm_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  mm_pkg::cmd_t              push_cmd,
    output logic                      push_ready,
    output logic                      pop_valid,
    output mm_pkg::cmd_t              pop_cmd,
    input  logic                      pop,
    output logic [mm_pkg::QCNT_W-1:0] count
);
    import mm_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hdl/mm_back.sv
// Back end: matrix stores, multiply-accumulate sequencer and result register.
// Depends on mm_pkg and mm_out_if.
module mm_back #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  mm_pkg::cmd_t  q_cmd,
    output logic          q_pop,
    input  mm_pkg::dims_t dims,
    mm_out_if.source      result
);
    import mm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] raw);
        logic [DIM_W-1:0] res;
        if (raw == '0)
        begin
            res = DIM_W'(1);
        end
        else if (32'(raw) > MAX_DIM)
        begin
            res = DIM_W'(MAX_DIM);
        end
        else
        begin
            res = DIM_W'(raw);
        end
        return res;
    endfunction

    logic [31:0] store_a [DEPTH];
    logic [31:0] store_b [DEPTH];

    back_state_t state_reg, state_next;

    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] n_last_reg, n_last_next;
    logic [IDX_W-1:0] m_last_reg, m_last_next;
    logic [IDX_W-1:0] inner_last_reg, inner_last_next;
    logic             err_reg, err_next;
    logic             v1_reg, v2_reg;

    logic [31:0] rd_a_reg, rd_b_reg;
    logic [31:0] prod_reg;
    logic [31:0] acc_reg, acc_next;

    logic               out_valid_reg;
    logic [2:0]         out_row_reg, out_col_reg;
    logic signed [31:0] out_value_reg;
    logic               out_last_reg, out_err_reg;

    logic              mismatch;
    logic              is_compute;
    logic              out_free;
    logic              last_entry;
    logic              issue;
    logic              load_out;
    logic              wr_a, wr_b;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

    assign mismatch   = (eff_dim(dims.cols_a) != eff_dim(dims.rows_b));
    assign is_compute = (q_cmd.kind == CMD_COMPUTE);
    assign out_free   = !out_valid_reg || result.ready;
    assign last_entry = (i_reg == n_last_reg) && (j_reg == m_last_reg);

    assign wr_addr   = ADDR_W'(32'(q_cmd.row) * 32'(MAX_DIM) + 32'(q_cmd.col));
    assign rd_addr_a = ADDR_W'(32'(i_reg) * 32'(MAX_DIM) + 32'(k_reg));
    assign rd_addr_b = ADDR_W'(32'(k_reg) * 32'(MAX_DIM) + 32'(j_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && is_compute)
                begin
                    state_next = mismatch ? ST_EMIT : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (k_reg == inner_last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (err_reg || last_entry) ? ST_IDLE : ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        q_pop    = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:  q_pop    = q_valid;
            ST_ISSUE: issue    = 1'b1;
            ST_EMIT:  load_out = out_free;
            default:  q_pop    = 1'b0;
        endcase
        wr_a = q_pop && (q_cmd.kind == CMD_LOAD_A);
        wr_b = q_pop && (q_cmd.kind == CMD_LOAD_B);
    end

    // Loop counters and accumulator
    always_comb
    begin
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        n_last_next     = n_last_reg;
        m_last_next     = m_last_reg;
        inner_last_next = inner_last_reg;
        err_next        = err_reg;
        acc_next        = v2_reg ? acc_reg + prod_reg : acc_reg;
        if (q_pop && is_compute)
        begin
            i_next          = '0;
            j_next          = '0;
            k_next          = '0;
            n_last_next     = IDX_W'(eff_dim(dims.rows_a) - DIM_W'(1));
            m_last_next     = IDX_W'(eff_dim(dims.cols_b) - DIM_W'(1));
            inner_last_next = IDX_W'(eff_dim(dims.cols_a) - DIM_W'(1));
            err_next        = mismatch;
            acc_next        = '0;
        end
        if (issue)
        begin
            k_next = (k_reg == inner_last_reg) ? '0 : k_reg + 1'b1;
        end
        if (load_out)
        begin
            acc_next = '0;
            if (j_reg == m_last_reg)
            begin
                j_next = '0;
                i_next = i_reg + 1'b1;
            end
            else
            begin
                j_next = j_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            n_last_reg     <= '0;
            m_last_reg     <= '0;
            inner_last_reg <= '0;
            err_reg        <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            n_last_reg     <= n_last_next;
            m_last_reg     <= m_last_next;
            inner_last_reg <= inner_last_next;
            err_reg        <= err_next;
            v1_reg         <= issue;
            v2_reg         <= v1_reg;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            store_a[wr_addr] <= q_cmd.value;
        end
        rd_a_reg <= store_a[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            store_b[wr_addr] <= q_cmd.value;
        end
        rd_b_reg <= store_b[rd_addr_b];
    end

    // Multiply, accumulate and result payload
    always_ff @(posedge clk)
    begin
        prod_reg <= rd_a_reg * rd_b_reg;
        acc_reg  <= acc_next;
        if (load_out)
        begin
            out_row_reg   <= err_reg ? 3'd0 : 3'(i_reg);
            out_col_reg   <= err_reg ? 3'd0 : 3'(j_reg);
            out_value_reg <= err_reg ? 32'sd0 : $signed(acc_reg);
            out_last_reg  <= err_reg || last_entry;
            out_err_reg   <= err_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_row       = out_row_reg;
    assign result.out_col       = out_col_reg;
    assign result.product_value = out_value_reg;
    assign result.last          = out_last_reg;
    assign result.dims_error    = out_err_reg;

endmodule

### hdl/integer_matrix_multiply.sv
// Top level of the integer matrix multiply block: C = A x B, signed 32-bit.
// Depends on mm_pkg, mm_if, mm_front, mm_queue and mm_back.
//
//   port       dir   kind           payload
//   operand    in    valid/ready    opcode, row_index, col_index, entry_value
//   result     out   valid/ready    out_row, out_col, product_value, last, dims_error
//   write_*    in    write strobe   reg_index, write_data (rows_a, cols_a, rows_b, cols_b)
//
// Loads are written from the back end's idle state, so they stream at one per cycle
// while no compute item is running. For each product entry a compute item issues
// the inner reads through both store read ports, drains the read, multiply and add
// stages and loads the result register; a dimension error loads it directly.
// Reset clears control state and sets all dimension registers to 8; stores are not
// cleared. A stalled result holds in the output register while the queue of four
// commands keeps accepting operand items.
module integer_matrix_multiply #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    mm_in_if.sink                        operand,
    mm_out_if.source                     result,
    input  logic                         write_enable,
    input  logic [mm_pkg::REG_IDX_W-1:0] reg_index,
    input  logic [mm_pkg::CFG_W-1:0]     write_data
);
    import mm_pkg::*;

    // Dimension registers
    logic [CFG_W-1:0] rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    dims_t            dims;

    // Front to queue, queue to back
    logic              push, push_ready;
    cmd_t              push_cmd;
    logic              q_valid, q_pop;
    cmd_t              q_cmd;
    logic [QCNT_W-1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= CFG_W'(8);
            cols_a_reg <= CFG_W'(8);
            rows_b_reg <= CFG_W'(8);
            cols_b_reg <= CFG_W'(8);
        end
        else if (write_enable)
        begin
            case (reg_index)
                REG_ROWS_A: rows_a_reg <= write_data;
                REG_COLS_A: cols_a_reg <= write_data;
                REG_ROWS_B: rows_b_reg <= write_data;
                REG_COLS_B: cols_b_reg <= write_data;
                default:    rows_a_reg <= rows_a_reg;
            endcase
        end
    end

    assign dims.rows_a = rows_a_reg;
    assign dims.cols_a = cols_a_reg;
    assign dims.rows_b = rows_b_reg;
    assign dims.cols_b = cols_b_reg;

    // Decode and drop no-op items
    mm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .operand    (operand),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    // Decouple accept from execution
    mm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd),
        .pop        (q_pop),
        .count      (q_count)
    );

    // Stores, multiply-accumulate and result register
    mm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .dims    (dims),
        .result  (result)
    );

    // An error result is a lone, zeroed, final item.
    a_err_format: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.dims_error |->
            result.last && result.product_value == 32'sd0 &&
            result.out_row == 3'd0 && result.out_col == 3'd0)
        else $error("dims error result not formatted as a lone final item");

    // An accepted compute item is held in the queue until the back end takes it.
    a_compute_queued: assert property (@(posedge clk) disable iff (!rst_n)
        operand.valid && operand.ready && operand.opcode == OP_COMPUTE |=>
            q_count != '0)
        else $error("compute item lost between front end and queue");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for integer_matrix_multiply: loads A and B, runs products, checks C.
// Depends on mm_pkg, mm_if and the block's RTL; needs no other file.
module testbench;
    import mm_pkg::*;

    localparam int HALF_PERIOD       = 6;
    localparam int RESET_CYCLES      = 2;
    localparam int SIDE              = MAX_DIM_DEF;
    // Four loads may still sit in the queue after the last result, so this margin covers
    // the block going quiet.
    localparam int DRAIN_CYCLES      = 16;
    localparam int LONG_HOLD         = 300;
    localparam int STALL_LIMIT       = 2000;
    localparam int TARGET_ITEMS      = 460;
    localparam int PRESSURE_COMPUTES = 10;

    // Opcode 3 is not decoded by the block: it must vanish without a result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [REG_IDX_W-1:0] DIM_REGS [4] =
        '{REG_ROWS_A, REG_COLS_A, REG_ROWS_B, REG_COLS_B};

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        last;
        logic        dims_error;
    } entry_t;

    typedef enum logic {
        STEP_DIMS,
        STEP_ITEM
    } step_kind_t;

    // One row of the directed table: either a new set of dimensions, or one operand item.
    // A row marked typed carries its product entry written out by hand; every other row
    // goes through the product forecast below.
    typedef struct packed {
        step_kind_t  kind;
        dims_t       dims;
        logic [1:0]  opcode;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        typed;
        entry_t      want;
    } step_t;

    localparam dims_t  NO_DIMS    = '0;
    localparam entry_t NO_ENTRY   = '0;
    localparam entry_t UNIT_ENTRY = '{3'd0, 3'd0, 32'd1, 1'b1, 1'b0};
    localparam entry_t NULL_ENTRY = '{3'd0, 3'd0, 32'd0, 1'b1, 1'b0};
    localparam entry_t DIMS_FAULT = '{3'd0, 3'd0, 32'd0, 1'b1, 1'b1};

    localparam int DIRECTED_LEN = 25;

    // Dimension nibbles read rows_a, cols_a, rows_b, cols_b from the left.
    localparam step_t DIRECTED [DIRECTED_LEN] = '{
        // 1x1 products at the corners of the 32-bit range: wrap of square terms
        '{STEP_DIMS, 16'h1111, OP_COMPUTE, 3'd0, 3'd0, 32'd0,          1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_LOAD_A,  3'd0, 3'd0, 32'h7FFF_FFFF,  1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_LOAD_B,  3'd0, 3'd0, 32'h7FFF_FFFF,  1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_COMPUTE, 3'd0, 3'd0, 32'd0,          1'b1, UNIT_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_LOAD_A,  3'd0, 3'd0, 32'h8000_0000,  1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_LOAD_B,  3'd0, 3'd0, 32'h8000_0000,  1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF,  1'b1, NULL_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_LOAD_A,  3'd0, 3'd0, 32'hFFFF_FFFF,  1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_LOAD_B,  3'd0, 3'd0, 32'hFFFF_FFFF,  1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_COMPUTE, 3'd0, 3'd0, 32'd0,          1'b1, UNIT_ENTRY},
        // undecoded opcode with every payload bit set
        '{STEP_ITEM, NO_DIMS,  OP_UNUSED,  3'd7, 3'd7, 32'hFFFF_FFFF,  1'b0, NO_ENTRY},
        // far corner of both stores
        '{STEP_ITEM, NO_DIMS,  OP_LOAD_A,  3'd7, 3'd7, 32'd0,          1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_LOAD_B,  3'd7, 3'd7, 32'hFFFF_FFFF,  1'b0, NO_ENTRY},
        // zero reads as one, fifteen as eight: inner dims 1 vs 8 must fault
        '{STEP_DIMS, 16'h00F0, OP_COMPUTE, 3'd0, 3'd0, 32'd0,          1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_COMPUTE, 3'd0, 3'd0, 32'd0,          1'b1, DIMS_FAULT},
        // zero inner dimension of A clamped to one, matching B's single row: a 2x2 outer product
        '{STEP_DIMS, 16'h2012, OP_COMPUTE, 3'd0, 3'd0, 32'd0,          1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_LOAD_A,  3'd1, 3'd0, 32'h1234_5678,  1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_LOAD_B,  3'd0, 3'd1, 32'h8000_0001,  1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_COMPUTE, 3'd0, 3'd0, 32'd0,          1'b0, NO_ENTRY},
        // inner dims 8 vs clamped 1
        '{STEP_DIMS, 16'h8808, OP_COMPUTE, 3'd0, 3'd0, 32'd0,          1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_COMPUTE, 3'd0, 3'd0, 32'd0,          1'b1, DIMS_FAULT},
        // row times column with a negative term
        '{STEP_DIMS, 16'h1221, OP_COMPUTE, 3'd0, 3'd0, 32'd0,          1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_LOAD_A,  3'd0, 3'd1, 32'd7,          1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_LOAD_B,  3'd1, 3'd0, 32'hFFFF_FFF9,  1'b0, NO_ENTRY},
        '{STEP_ITEM, NO_DIMS,  OP_COMPUTE, 3'd0, 3'd0, 32'd0,          1'b0, NO_ENTRY}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 write_enable;
    logic [REG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     write_data;

    mm_in_if  operand_bus ();
    mm_out_if result_bus ();

    // Shadow of the block: both stores, which entries hold data, and the dimensions.
    logic [31:0] mirror_a [SIDE*SIDE];
    logic [31:0] mirror_b [SIDE*SIDE];
    bit          a_written [SIDE*SIDE];
    bit          b_written [SIDE*SIDE];
    dims_t       dims_shadow;

    entry_t      awaited [$];
    int unsigned items_sent;
    int unsigned failures;
    int unsigned stuck_cycles;
    bit          sender_eager;
    bit          hold_off_req;

    integer_matrix_multiply i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .operand      (operand_bus),
        .result       (result_bus),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Effective size of one dimension register: zero acts as one, anything past the
    // store side acts as the full side.
    function automatic int span(logic [CFG_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > SIDE)
            return SIDE;
        return raw;
    endfunction

    // Mostly back to back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Raw register value, biased to small sizes with a share of clamped extremes.
    function automatic logic [CFG_W-1:0] pick_raw_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 12)
            return CFG_W'($urandom_range(SIDE + 1, (1 << CFG_W) - 1));
        if (roll < 18)
            return CFG_W'(SIDE);
        if (roll < 30)
            return CFG_W'($urandom_range(4, SIDE - 1));
        return CFG_W'($urandom_range(1, 3));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(0, 1));
            default: return $urandom;
        endcase
    endfunction

    function automatic string describe(entry_t e);
        return $sformatf("row %0d col %0d value %0d last %0b dims_error %0b",
                         e.row, e.col, $signed(e.value), e.last, e.dims_error);
    endfunction

    // Apply one accepted item to the shadow and queue the product entries it yields.
    function automatic void forecast_product(logic [1:0] op, logic [2:0] row,
                                             logic [2:0] col, logic [31:0] value);
        int          addr;
        int          rows_out;
        int          inner;
        int          cols_out;
        logic [31:0] acc;
        entry_t      e;
        addr = row * SIDE + col;
        case (op)
            OP_LOAD_A:
            begin
                mirror_a[addr]  = value;
                a_written[addr] = 1'b1;
            end
            OP_LOAD_B:
            begin
                mirror_b[addr]  = value;
                b_written[addr] = 1'b1;
            end
            OP_COMPUTE:
            begin
                rows_out = span(dims_shadow.rows_a);
                inner    = span(dims_shadow.cols_a);
                cols_out = span(dims_shadow.cols_b);
                if (inner != span(dims_shadow.rows_b))
                    awaited.push_back(DIMS_FAULT);
                else
                begin
                    for (int i = 0; i < rows_out; i++)
                    begin
                        for (int j = 0; j < cols_out; j++)
                        begin
                            // 32-bit context keeps only the low word of each product
                            acc = '0;
                            for (int k = 0; k < inner; k++)
                                acc = acc + mirror_a[i * SIDE + k] * mirror_b[k * SIDE + j];
                            e.row        = 3'(i);
                            e.col        = 3'(j);
                            e.value      = acc;
                            e.last       = (i == rows_out - 1) && (j == cols_out - 1);
                            e.dims_error = 1'b0;
                            awaited.push_back(e);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one item, after a random gap unless eager; hold it until taken, then book it.
    task automatic send_item(input logic [1:0] op, input logic [2:0] row,
                             input logic [2:0] col, input logic [31:0] value,
                             input bit typed, input entry_t want);
        int gap;
        gap = sender_eager ? 0 : pick_gap();
        if (gap > 0)
        begin
            operand_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operand_bus.valid       <= 1'b1;
        operand_bus.opcode      <= op;
        operand_bus.row_index   <= row;
        operand_bus.col_index   <= col;
        operand_bus.entry_value <= value;
        do @(posedge clk); while (!operand_bus.ready);
        if (typed)
            awaited.push_back(want);
        else
            forecast_product(op, row, col, value);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Drop valid, wait for every pending entry, then let queued loads drain.
    task automatic settle();
        operand_bus.valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Reprogram all four dimensions while the block is quiet.
    task automatic write_dims(input dims_t d);
        logic [CFG_W-1:0] vals [4];
        settle();
        vals = '{d.rows_a, d.cols_a, d.rows_b, d.cols_b};
        for (int r = 0; r < 4; r++)
        begin
            write_enable <= 1'b1;
            reg_index    <= DIM_REGS[r];
            write_data   <= vals[r];
            @(posedge clk);
        end
        write_enable <= 1'b0;
        dims_shadow  = d;
    endtask

    // Occasionally slip in an undecoded item or a load anywhere in the stores.
    task automatic maybe_noise();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            send_item(OP_UNUSED, 3'($urandom), 3'($urandom), $urandom, 1'b0, NO_ENTRY);
        else if (roll < 10)
            send_item($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A, 3'($urandom),
                      3'($urandom), pick_value(), 1'b0, NO_ENTRY);
    endtask

    // Fill every entry the next product reads that was never written, and refresh a
    // third of the others so the content keeps moving.
    task automatic load_operands(input int rows_out, input int inner, input int cols_out);
        for (int i = 0; i < rows_out; i++)
            for (int k = 0; k < inner; k++)
                if (!a_written[i * SIDE + k] || $urandom_range(0, 2) == 0)
                begin
                    maybe_noise();
                    send_item(OP_LOAD_A, 3'(i), 3'(k), pick_value(), 1'b0, NO_ENTRY);
                end
        for (int k = 0; k < inner; k++)
            for (int j = 0; j < cols_out; j++)
                if (!b_written[k * SIDE + j] || $urandom_range(0, 2) == 0)
                begin
                    maybe_noise();
                    send_item(OP_LOAD_B, 3'(k), 3'(j), pick_value(), 1'b0, NO_ENTRY);
                end
    endtask

    // One random phase: new dimensions, then one to three load-and-compute rounds.
    // About one phase in seven uses mismatched inner dimensions.
    task automatic run_phase();
        dims_t d;
        bit    fault;
        int    rounds;
        d.rows_a = pick_raw_dim();
        d.cols_a = pick_raw_dim();
        d.rows_b = pick_raw_dim();
        d.cols_b = pick_raw_dim();
        fault    = ($urandom_range(0, 99) < 15);
        if (fault)
            while (span(d.cols_a) == span(d.rows_b))
                d.rows_b = pick_raw_dim();
        else
            while (span(d.cols_a) != span(d.rows_b))
                d.rows_b = pick_raw_dim();
        write_dims(d);
        sender_eager = ($urandom_range(0, 4) == 0);
        rounds = $urandom_range(1, 3);
        for (int r = 0; r < rounds; r++)
        begin
            if (!fault)
                load_operands(span(d.rows_a), span(d.cols_a), span(d.cols_b));
            maybe_noise();
            send_item(OP_COMPUTE, 3'($urandom), 3'($urandom), $urandom, 1'b0, NO_ENTRY);
        end
        sender_eager = 1'b0;
    endtask

    // Stall the result side for a long stretch while computes keep coming, so the
    // command queue and the output register fill and the operand side backs up.
    task automatic pressure_phase();
        dims_t d;
        d = 16'h2222;
        write_dims(d);
        load_operands(2, 2, 2);
        hold_off_req = 1'b1;
        sender_eager = 1'b1;
        repeat (PRESSURE_COMPUTES)
            send_item(OP_COMPUTE, 3'($urandom), 3'($urandom), $urandom, 1'b0, NO_ENTRY);
        sender_eager = 1'b0;
    endtask

    // Result side: random stalls between runs of ready, plus the long hold on request.
    initial
    begin : result_sink
        int   hold_left;
        int   stall_left;
        int   run_left;
        logic take;
        hold_left  = 0;
        stall_left = 0;
        run_left   = 0;
        result_bus.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_left    = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                take = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                take = 1'b0;
                stall_left--;
            end
            else
            begin
                take = 1'b1;
                if (run_left > 0)
                    run_left--;
                else
                begin
                    stall_left = pick_gap();
                    run_left   = $urandom_range(0, 24);
                end
            end
            result_bus.ready <= take;
            @(posedge clk);
        end
    end

    // Compare every accepted result with the oldest pending product entry.
    always @(posedge clk)
    begin : result_check
        entry_t got;
        entry_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = '{result_bus.out_row, result_bus.out_col, result_bus.product_value,
                    result_bus.last, result_bus.dims_error};
            if (awaited.size() == 0)
            begin
                $display("%0t: result with nothing pending: expected none, got %s",
                         $time, describe(got));
                failures++;
            end
            else
            begin
                want = awaited.pop_front();
                if (got !== want)
                begin
                    $display("%0t: result mismatch: expected %s, got %s",
                             $time, describe(want), describe(got));
                    failures++;
                end
            end
        end
    end

    // End the run if neither side moves an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (operand_bus.valid && operand_bus.ready)
                   || (result_bus.valid && result_bus.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Main sequence: reset, directed table, pressure, random phases, drain, verdict.
    initial
    begin
        step_t step;
        items_sent   = 0;
        failures     = 0;
        stuck_cycles = 0;
        sender_eager = 1'b0;
        hold_off_req = 1'b0;
        dims_shadow  = '{4'd8, 4'd8, 4'd8, 4'd8};
        rst_n                   <= 1'b0;
        write_enable            <= 1'b0;
        reg_index               <= '0;
        write_data              <= '0;
        operand_bus.valid       <= 1'b0;
        operand_bus.opcode      <= OP_LOAD_A;
        operand_bus.row_index   <= '0;
        operand_bus.col_index   <= '0;
        operand_bus.entry_value <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int s = 0; s < DIRECTED_LEN; s++)
        begin
            step = DIRECTED[s];
            if (step.kind == STEP_DIMS)
                write_dims(step.dims);
            else
                send_item(step.opcode, step.row, step.col, step.value, step.typed, step.want);
        end

        pressure_phase();

        while (items_sent < TARGET_ITEMS)
            run_phase();

        settle();
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### integer_matrix_multiply.f
hdl/mm_pkg.sv
hdl/mm_if.sv
hdl/mm_front.sv
hdl/mm_queue.sv
hdl/mm_back.sv
hdl/integer_matrix_multiply.sv
tb/testbench.sv
